>>> rtl/huffman_tree_walk_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman tree walk decoder
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_TOP_MACROS_SVH

// Same-cycle implication.
`define HWD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HWD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hwd_pkg.sv
// ----------------------------------------------------------------------------
// hwd_pkg
// Types, constants and codes shared by the Huffman tree walk decoder.
// ----------------------------------------------------------------------------
package hwd_pkg;

  localparam int NODE_DEPTH      = 512;
  localparam int IDX_W           = $clog2(NODE_DEPTH);
  localparam int WORD_BITS       = 32;
  localparam int SYMBOL_BITS     = 8;
  localparam int CNT_W           = 32;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int BIT_IDX_W       = $clog2(WORD_BITS);
  localparam int BIT_CNT_W       = $clog2(WORD_BITS + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_WORDS = 2'd2;

  localparam logic FUNC_NODE_WRITE = 1'b0;
  localparam logic FUNC_DECODE     = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [IDX_W-1:0]       node_index;
    logic                   node_is_leaf;
    logic [IDX_W-1:0]       left_child;
    logic [IDX_W-1:0]       right_child;
    logic [SYMBOL_BITS-1:0] node_symbol;
    logic [WORD_BITS-1:0]   code_word;
  } in_word_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   last;
    logic                   finished;
  } out_word_t;

  typedef struct packed {
    logic                   leaf;
    logic [IDX_W-1:0]       left;
    logic [IDX_W-1:0]       right;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  typedef enum logic {
    CMD_NODE,
    CMD_WORD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [IDX_W-1:0]     node_index;
    node_t                node;
    logic [WORD_BITS-1:0] code_word;
  } cmd_t;

  typedef struct packed {
    logic                   push;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   commit;
    logic                   finished;
  } obuf_wr_t;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_LOAD,
    WS_STEP,
    WS_FIN
  } walk_state_t;

endpackage

>>> rtl/huffman_tree_walk_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top
// Huffman tree decoder: node writes fill the tree, code words are walked
// bit by bit from the top down and each reached leaf yields one symbol.
//
//   Channel   Direction  Handshake          Word
//   input     in         push / full        in_word  (node write or code word)
//   result    out        pop / empty        out_word (symbol, last, finished)
//   config    in         cfg_we             cfg_index, cfg_data
//
// A node write is done by the walker straight from idle; a decode word is
// accepted, loaded, walked one tree step per code bit and then wrapped up.
// Its symbols are then drained before the next word starts. Ignored words are
// popped without a walk. Reset is synchronous and needs no clearing pass. The
// input queue keeps accepting while the walker stalls, until it is full.
// ----------------------------------------------------------------------------
`include "huffman_tree_walk_decoder_top_macros.svh"

module huffman_tree_walk_decoder_top #(
  parameter int QUEUE_DEPTH = hwd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  hwd_pkg::in_word_t             in_word,
  output logic                          empty,
  input  logic                          pop,
  output hwd_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [hwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hwd_pkg::CFG_W-1:0]     cfg_data
);
  import hwd_pkg::*;

  logic     cmd_valid;
  cmd_t     cmd;
  logic     cmd_pop;
  logic     obuf_busy;
  obuf_wr_t obuf_wr;

  hwd_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  hwd_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .obuf_busy(obuf_busy),
    .obuf_wr  (obuf_wr)
  );

  hwd_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .obuf_wr (obuf_wr),
    .busy    (obuf_busy),
    .empty   (empty),
    .pop     (pop),
    .out_word(out_word)
  );

  `HWD_ASSERT_IMP(a_no_push_while_drain, obuf_busy, !obuf_wr.push, "symbol written while draining")
  `HWD_ASSERT_NXT(a_empty_after_last, pop && !empty && out_word.last, empty, "result after last")
  `HWD_ASSERT_NXT(a_finished_steady, pop && !empty && !out_word.last, out_word.finished == $past(out_word.finished), "finished changed within a word")

endmodule

>>> rtl/hwd_front.sv
// ----------------------------------------------------------------------------
// hwd_front
// Accepts input words, classifies them into node writes and decode commands
// and holds them in a short queue for the tree walker.
// ----------------------------------------------------------------------------
module hwd_front #(
  parameter int QUEUE_DEPTH = hwd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  hwd_pkg::in_word_t in_word,
  output logic             cmd_valid,
  output hwd_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);
  import hwd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  cmd_t              cmd_in;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    cmd_in.kind       = (in_word.func == FUNC_DECODE) ? CMD_WORD : CMD_NODE;
    cmd_in.node_index = in_word.node_index;
    cmd_in.node.leaf  = in_word.node_is_leaf;
    cmd_in.node.left  = in_word.left_child;
    cmd_in.node.right = in_word.right_child;
    cmd_in.node.sym   = in_word.node_symbol;
    cmd_in.code_word  = in_word.code_word;
  end

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/hwd_walk.sv
// ----------------------------------------------------------------------------
// hwd_walk
// Holds the node memory and the configuration, carries out node writes and
// walks the tree one code bit per cycle, handing symbols to the result buffer.
// ----------------------------------------------------------------------------
module hwd_walk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hwd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             cmd_valid,
  input  hwd_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  input  logic                             obuf_busy,
  output hwd_pkg::obuf_wr_t                obuf_wr
);
  import hwd_pkg::*;

  node_t                node_mem [NODE_DEPTH];
  node_t                data_a_r;
  node_t                root_ent_r;
  walk_state_t          state_r;
  walk_state_t          state_nxt;
  logic [IDX_W-1:0]     root_r;
  logic [CNT_W-1:0]     total_bits_r;
  logic [CNT_W-1:0]     total_words_r;
  logic [IDX_W-1:0]     cur_idx_r;
  logic [IDX_W-1:0]     cur_idx_nxt;
  logic [CNT_W-1:0]     bits_used_r;
  logic [CNT_W-1:0]     bits_used_nxt;
  logic [CNT_W-1:0]     words_used_r;
  logic [CNT_W-1:0]     words_used_nxt;
  logic                 stopped_r;
  logic                 stopped_nxt;
  logic [WORD_BITS-1:0] shift_r;
  logic [WORD_BITS-1:0] shift_nxt;
  logic [BIT_IDX_W-1:0] bit_cnt_r;
  logic [BIT_IDX_W-1:0] bit_cnt_nxt;
  logic                 chk_r;
  logic                 chk_nxt;
  logic                 lim_r;
  logic                 lim_nxt;
  logic [IDX_W-1:0]     addr_a;
  logic                 mem_we;
  logic                 word_skip;
  logic                 leaf_hit;
  node_t                ent;
  logic [IDX_W-1:0]     child;
  logic [CNT_W-1:0]     bits_inc;
  logic [CNT_W-1:0]     words_inc;
  logic                 bit_lim;
  logic                 last_bit;

  assign word_skip = stopped_r || (words_used_r >= total_words_r);
  assign leaf_hit  = chk_r && data_a_r.leaf;
  assign ent       = leaf_hit ? root_ent_r : data_a_r;
  assign child     = shift_r[WORD_BITS-1] ? ent.right : ent.left;
  assign bits_inc  = bits_used_r + CNT_W'(1);
  assign words_inc = words_used_r + CNT_W'(1);
  assign bit_lim   = (bits_inc == total_bits_r);
  assign last_bit  = (bit_cnt_r == BIT_IDX_W'(WORD_BITS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      WS_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_WORD && !word_skip && !obuf_busy) begin
          state_nxt = WS_LOAD;
        end
      end
      WS_LOAD: begin
        state_nxt = WS_STEP;
      end
      WS_STEP: begin
        if (bit_lim || last_bit) begin
          state_nxt = WS_FIN;
        end
      end
      WS_FIN: begin
        state_nxt = WS_IDLE;
      end
      default: begin
        state_nxt = WS_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    addr_a         = cur_idx_r;
    obuf_wr        = '0;
    cur_idx_nxt    = cur_idx_r;
    bits_used_nxt  = bits_used_r;
    words_used_nxt = words_used_r;
    stopped_nxt    = stopped_r;
    shift_nxt      = shift_r;
    bit_cnt_nxt    = bit_cnt_r;
    chk_nxt        = chk_r;
    lim_nxt        = lim_r;
    unique case (state_r)
      WS_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == CMD_NODE) begin
            cmd_pop = 1'b1;
            mem_we  = 1'b1;
          end else if (word_skip) begin
            cmd_pop     = 1'b1;
            stopped_nxt = 1'b1;
          end else if (!obuf_busy) begin
            cmd_pop     = 1'b1;
            shift_nxt   = cmd.code_word;
            bit_cnt_nxt = '0;
            chk_nxt     = 1'b0;
            lim_nxt     = 1'b0;
          end
        end
      end
      WS_LOAD: begin
        addr_a = cur_idx_r;
      end
      WS_STEP: begin
        obuf_wr.push   = leaf_hit;
        obuf_wr.symbol = data_a_r.sym;
        addr_a         = child;
        cur_idx_nxt    = child;
        shift_nxt      = {shift_r[WORD_BITS-2:0], 1'b0};
        bits_used_nxt  = bits_inc;
        lim_nxt        = bit_lim;
        bit_cnt_nxt    = bit_cnt_r + BIT_IDX_W'(1);
        chk_nxt        = 1'b1;
      end
      WS_FIN: begin
        obuf_wr.push   = leaf_hit;
        obuf_wr.symbol = data_a_r.sym;
        if (leaf_hit) begin
          cur_idx_nxt = root_r;
        end
        words_used_nxt   = words_inc;
        stopped_nxt      = stopped_r || lim_r || (words_inc == total_words_r);
        obuf_wr.commit   = 1'b1;
        obuf_wr.finished = stopped_nxt;
      end
      default: begin
        addr_a = cur_idx_r;
      end
    endcase
    if (cfg_we && cfg_index == CFG_ROOT_NODE) begin
      cur_idx_nxt = cfg_data[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[cmd.node_index] <= cmd.node;
    end
    data_a_r   <= node_mem[addr_a];
    root_ent_r <= node_mem[root_r];
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= WS_IDLE;
      root_r        <= '0;
      total_bits_r  <= '0;
      total_words_r <= '0;
      cur_idx_r     <= '0;
      bits_used_r   <= '0;
      words_used_r  <= '0;
      stopped_r     <= 1'b0;
      bit_cnt_r     <= '0;
      chk_r         <= 1'b0;
      lim_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_idx_r    <= cur_idx_nxt;
      bits_used_r  <= bits_used_nxt;
      words_used_r <= words_used_nxt;
      stopped_r    <= stopped_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      chk_r        <= chk_nxt;
      lim_r        <= lim_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROOT_NODE:   root_r        <= cfg_data[IDX_W-1:0];
          CFG_TOTAL_BITS:  total_bits_r  <= cfg_data[CNT_W-1:0];
          CFG_TOTAL_WORDS: total_words_r <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/hwd_obuf.sv
// ----------------------------------------------------------------------------
// hwd_obuf
// Collects the symbols of one code word and, once the word is complete,
// presents them in order with the last and finished flags.
// ----------------------------------------------------------------------------
module hwd_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  hwd_pkg::obuf_wr_t  obuf_wr,
  output logic               busy,
  output logic               empty,
  input  logic               pop,
  output hwd_pkg::out_word_t out_word
);
  import hwd_pkg::*;

  logic [SYMBOL_BITS-1:0] sym_r [WORD_BITS];
  logic [BIT_CNT_W-1:0]   wcnt_r;
  logic [BIT_CNT_W-1:0]   wcnt_nxt;
  logic [BIT_IDX_W-1:0]   rd_r;
  logic [BIT_IDX_W-1:0]   rd_nxt;
  logic                   draining_r;
  logic                   draining_nxt;
  logic                   fin_r;
  logic                   is_last;

  assign is_last = ((BIT_CNT_W'(rd_r) + BIT_CNT_W'(1)) == wcnt_r);
  assign busy    = draining_r;
  assign empty   = !draining_r;

  always_comb begin
    out_word.symbol   = sym_r[rd_r];
    out_word.last     = is_last;
    out_word.finished = fin_r;
  end

  always_comb begin
    wcnt_nxt     = wcnt_r;
    rd_nxt       = rd_r;
    draining_nxt = draining_r;
    if (obuf_wr.push) begin
      wcnt_nxt = wcnt_r + BIT_CNT_W'(1);
    end
    if (obuf_wr.commit) begin
      draining_nxt = (wcnt_nxt != '0);
    end
    if (pop && draining_r) begin
      if (is_last) begin
        draining_nxt = 1'b0;
        wcnt_nxt     = '0;
        rd_nxt       = '0;
      end else begin
        rd_nxt = rd_r + BIT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (obuf_wr.push) begin
      sym_r[wcnt_r[BIT_IDX_W-1:0]] <= obuf_wr.symbol;
    end
    if (obuf_wr.commit) begin
      fin_r <= obuf_wr.finished;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r     <= '0;
      rd_r       <= '0;
      draining_r <= 1'b0;
    end else begin
      wcnt_r     <= wcnt_nxt;
      rd_r       <= rd_nxt;
      draining_r <= draining_nxt;
    end
  end

endmodule
